// ----- rtl/grid_dda_line_of_sight_assert.svh -----
// ----------------------------------------------------------------------------
// Grid line-of-sight assertion macros
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef GRID_DDA_LINE_OF_SIGHT_ASSERT_SVH
`define GRID_DDA_LINE_OF_SIGHT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GDLOS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdlos same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define GDLOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdlos next-cycle check failed");

`endif

// ----- rtl/gdlos_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdlos_pkg
// Shared widths, parameter defaults, item codes and FSM states.
// ----------------------------------------------------------------------------
package gdlos_pkg;

  localparam int COORD_W      = 14;
  localparam int CELL_IDX_W   = 6;
  localparam int STEP_COUNT_W = 8;

  localparam int MAP_WIDTH_DEF     = 64;
  localparam int MAP_HEIGHT_DEF    = 64;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int STEP_LIMIT_DEF    = 128;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_WALK
  } state_e;

endpackage

// ----- rtl/grid_dda_line_of_sight.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dda_line_of_sight
// Blocked-tile map in a 1-bit synchronous RAM plus a DDA walker that reads
// one map cell per step to answer line-of-sight queries.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  command   | start, busy          | mode_i, cell_col_i, cell_row_i,
//            |                      | cell_blocked_i, start_x_i, start_y_i,
//            |                      | finish_x_i, finish_y_i
//  result    | result_valid_o       | visible_o, step_count_o
//
//  Load beat: written into the map RAM at the accept edge; no result.
//  Query beat: busy in ST_MUL_X, ST_MUL_Y and ST_WALK, taking 0..STEP_LIMIT
//  steps. The MUL states form the crossing products on one shared
//  multiplier; ST_WALK then steps cell by cell, one RAM read per in-map cell.
//  The result strobe follows for one cycle; a new beat may be taken then.
//  Reset clears control only; map cells read undefined until loaded.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "grid_dda_line_of_sight_assert.svh"

module grid_dda_line_of_sight #(
  parameter int MAP_WIDTH     = gdlos_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT    = gdlos_pkg::MAP_HEIGHT_DEF,
  parameter int FRACTION_BITS = gdlos_pkg::FRACTION_BITS_DEF,
  parameter int STEP_LIMIT    = gdlos_pkg::STEP_LIMIT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 mode_i,
  input  logic [gdlos_pkg::CELL_IDX_W-1:0]     cell_col_i,
  input  logic [gdlos_pkg::CELL_IDX_W-1:0]     cell_row_i,
  input  logic                                 cell_blocked_i,
  input  logic [gdlos_pkg::COORD_W-1:0]        start_x_i,
  input  logic [gdlos_pkg::COORD_W-1:0]        start_y_i,
  input  logic [gdlos_pkg::COORD_W-1:0]        finish_x_i,
  input  logic [gdlos_pkg::COORD_W-1:0]        finish_y_i,
  output logic                                 result_valid_o,
  output logic                                 visible_o,
  output logic [gdlos_pkg::STEP_COUNT_W-1:0]   step_count_o
);

  localparam int CW      = gdlos_pkg::COORD_W - FRACTION_BITS;
  localparam int MW_BITS = $clog2(MAP_WIDTH + 1);
  localparam int MH_BITS = $clog2(MAP_HEIGHT + 1);
  localparam int MB0     = (CW > MW_BITS) ? CW : MW_BITS;
  localparam int MB      = (MB0 > MH_BITS) ? MB0 : MH_BITS;
  localparam int CXW     = MB + 2;
  localparam int N0W     = FRACTION_BITS + 1;
  localparam int KW      = $clog2(STEP_LIMIT + 1);
  localparam int PW      = KW + FRACTION_BITS + gdlos_pkg::COORD_W + 1;
  localparam int DEPTH   = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int CELL_ONE = 1 << FRACTION_BITS;

  gdlos_pkg::state_e state_q, state_d;

  logic                          res_valid_q, res_valid_d;
  logic                          res_vis_q, res_vis_d;
  logic [KW-1:0]                 res_cnt_q, res_cnt_d;

  logic [gdlos_pkg::COORD_W-1:0] adx_q, adx_d, ady_q, ady_d;
  logic                          negx_q, negx_d, negy_q, negy_d;
  logic signed [CXW-1:0]         cx_q, cx_d, cy_q, cy_d, ex_q, ex_d, ey_q, ey_d;
  logic [N0W-1:0]                nx0_q, nx0_d, ny0_q, ny0_d;
  logic [PW-1:0]                 px_q, px_d, py_q, py_d;
  logic [KW-1:0]                 k_q, k_d;
  logic                          check_q, check_d, out_q, out_d;

  logic                          blocked_map_q [DEPTH];
  logic                          rd_data_q;
  logic                          rd_en, wr_en;
  logic [AW-1:0]                 rd_addr, wr_addr;

  logic                          accept;
  logic [N0W-1:0]                mul_a;
  logic [gdlos_pkg::COORD_W-1:0] mul_b;
  logic [PW-1:0]                 mul_p;
  logic                          take_x, in_map, blocked_hit, at_end, at_limit;
  logic signed [CXW-1:0]         nxt_cx, nxt_cy;
  logic [FRACTION_BITS-1:0]      fx, fy;

  assign busy   = (state_q != gdlos_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign result_valid_o = res_valid_q;
  assign visible_o      = res_vis_q;
  assign step_count_o   = gdlos_pkg::STEP_COUNT_W'(res_cnt_q);

  // load port
  assign wr_en   = accept && (mode_i == gdlos_pkg::MODE_LOAD)
                   && (int'(cell_col_i) < MAP_WIDTH) && (int'(cell_row_i) < MAP_HEIGHT);
  assign wr_addr = AW'(cell_row_i) * AW'(MAP_WIDTH) + AW'(cell_col_i);

  // shared multiplier for the initial crossing products
  assign mul_a = (state_q == gdlos_pkg::ST_MUL_X) ? nx0_q : ny0_q;
  assign mul_b = (state_q == gdlos_pkg::ST_MUL_X) ? ady_q : adx_q;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign fx = start_x_i[FRACTION_BITS-1:0];
  assign fy = start_y_i[FRACTION_BITS-1:0];

  // walk step decision; ties go to y
  assign take_x = (adx_q != '0) && ((ady_q == '0) || (px_q < py_q));
  assign nxt_cx = take_x ? (negx_q ? cx_q - CXW'(1) : cx_q + CXW'(1)) : cx_q;
  assign nxt_cy = take_x ? cy_q : (negy_q ? cy_q - CXW'(1) : cy_q + CXW'(1));
  assign in_map = (nxt_cx >= 0) && (nxt_cx < $signed(CXW'(MAP_WIDTH)))
                  && (nxt_cy >= 0) && (nxt_cy < $signed(CXW'(MAP_HEIGHT)));
  assign rd_addr = AW'($unsigned(nxt_cy)) * AW'(MAP_WIDTH) + AW'($unsigned(nxt_cx));

  assign blocked_hit = check_q && (out_q || rd_data_q);
  assign at_end      = (cx_q == ex_q) && (cy_q == ey_q);
  assign at_limit    = (k_q == KW'(STEP_LIMIT));

  always_comb begin
    state_d     = state_q;
    res_valid_d = 1'b0;
    res_vis_d   = res_vis_q;
    res_cnt_d   = res_cnt_q;
    adx_d   = adx_q;
    ady_d   = ady_q;
    negx_d  = negx_q;
    negy_d  = negy_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    nx0_d   = nx0_q;
    ny0_d   = ny0_q;
    px_d    = px_q;
    py_d    = py_q;
    k_d     = k_q;
    check_d = check_q;
    out_d   = out_q;
    rd_en   = 1'b0;
    case (state_q)
      gdlos_pkg::ST_IDLE: begin
        if (accept && (mode_i == gdlos_pkg::MODE_QUERY)) begin
          negx_d  = finish_x_i < start_x_i;
          negy_d  = finish_y_i < start_y_i;
          adx_d   = negx_d ? start_x_i - finish_x_i : finish_x_i - start_x_i;
          ady_d   = negy_d ? start_y_i - finish_y_i : finish_y_i - start_y_i;
          cx_d    = $signed(CXW'(start_x_i >> FRACTION_BITS));
          cy_d    = $signed(CXW'(start_y_i >> FRACTION_BITS));
          ex_d    = $signed(CXW'(finish_x_i >> FRACTION_BITS));
          ey_d    = $signed(CXW'(finish_y_i >> FRACTION_BITS));
          nx0_d   = negx_d ? N0W'(fx) : N0W'(CELL_ONE) - N0W'(fx);
          ny0_d   = negy_d ? N0W'(fy) : N0W'(CELL_ONE) - N0W'(fy);
          k_d     = '0;
          check_d = 1'b0;
          out_d   = 1'b0;
          state_d = gdlos_pkg::ST_MUL_X;
        end
      end
      gdlos_pkg::ST_MUL_X: begin
        px_d    = mul_p;
        state_d = gdlos_pkg::ST_MUL_Y;
      end
      gdlos_pkg::ST_MUL_Y: begin
        py_d    = mul_p;
        state_d = gdlos_pkg::ST_WALK;
      end
      gdlos_pkg::ST_WALK: begin
        if (blocked_hit || at_limit || at_end) begin
          res_valid_d = 1'b1;
          res_vis_d   = !blocked_hit && !at_limit;
          res_cnt_d   = k_q;
          state_d     = gdlos_pkg::ST_IDLE;
        end else begin
          cx_d    = nxt_cx;
          cy_d    = nxt_cy;
          k_d     = k_q + KW'(1);
          check_d = 1'b1;
          out_d   = !in_map;
          rd_en   = in_map;
          if (take_x) begin
            px_d = px_q + (PW'(ady_q) << FRACTION_BITS);
          end else begin
            py_d = py_q + (PW'(adx_q) << FRACTION_BITS);
          end
        end
      end
      default: begin
        state_d = gdlos_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdlos_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_vis_q <= res_vis_d;
    res_cnt_q <= res_cnt_d;
    adx_q     <= adx_d;
    ady_q     <= ady_d;
    negx_q    <= negx_d;
    negy_q    <= negy_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    ex_q      <= ex_d;
    ey_q      <= ey_d;
    nx0_q     <= nx0_d;
    ny0_q     <= ny0_d;
    px_q      <= px_d;
    py_q      <= py_d;
    k_q       <= k_d;
    check_q   <= check_d;
    out_q     <= out_d;
  end

  // map RAM: loads only while idle, reads only while walking
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      blocked_map_q[wr_addr] <= cell_blocked_i;
    end
    if (rd_en) begin
      rd_data_q <= blocked_map_q[rd_addr];
    end
  end

  `GDLOS_ASSERT_NOW(a_result_when_idle, clk_i, rst_ni, result_valid_o, !busy)
  `GDLOS_ASSERT_NEXT(a_query_goes_busy, clk_i, rst_ni,
    accept && (mode_i == gdlos_pkg::MODE_QUERY), busy)
  `GDLOS_ASSERT_NOW(a_step_in_range, clk_i, rst_ni,
    state_q == gdlos_pkg::ST_WALK, k_q <= KW'(STEP_LIMIT))
  `GDLOS_ASSERT_NOW(a_read_backs_check, clk_i, rst_ni,
    (state_q == gdlos_pkg::ST_WALK) && check_q && !out_q, $past(rd_en))
  `GDLOS_ASSERT_NOW(a_no_write_while_walk, clk_i, rst_ni, busy, !wr_en)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: grid line-of-sight block
// Fills a walled corner of the blocked map, then runs directed and random load
// and query beats under several sender idling phases. Random queries start
// inside the wall, and every walk stays on loaded cells. A scoreboard keeps
// its own map copy, walks each query cell by cell and checks every result strobe.
// ----------------------------------------------------------------------------
module tb_top;
  import gdlos_pkg::*;

  localparam int MAP_W      = MAP_WIDTH_DEF;
  localparam int MAP_H      = MAP_HEIGHT_DEF;
  localparam int MAP_CELLS  = MAP_W * MAP_H;
  localparam int FB         = FRACTION_BITS_DEF;
  localparam int WALK_LIMIT = STEP_LIMIT_DEF;
  localparam longint ONE    = longint'(1) << FB;
  localparam int FRAC_MASK  = (1 << FB) - 1;
  localparam int REGION     = 32;
  localparam int INNER      = REGION - 1;

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [CELL_IDX_W-1:0] cell_t;

  typedef struct packed {
    logic   mode;
    cell_t  col;
    cell_t  row;
    logic   blk;
    coord_t sx;
    coord_t sy;
    coord_t fx;
    coord_t fy;
  } cmd_t;

  typedef struct packed {
    logic                    seen;
    logic [STEP_COUNT_W-1:0] steps;
  } sight_t;

  class sight_scoreboard;
    bit     blocked_cell [MAP_CELLS];
    sight_t pending [$];
    int     errors;

    function sight_t trace_sight(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
      sight_t r;
      bit     neg_x, neg_y, go_x;
      longint adx, ady, nx, ny;
      int     cx, cy, ex, ey;
      neg_x = x1 < x0;
      neg_y = y1 < y0;
      adx = neg_x ? longint'(x0) - longint'(x1) : longint'(x1) - longint'(x0);
      ady = neg_y ? longint'(y0) - longint'(y1) : longint'(y1) - longint'(y0);
      cx = int'(x0 >> FB);
      cy = int'(y0 >> FB);
      ex = int'(x1 >> FB);
      ey = int'(y1 >> FB);
      nx = neg_x ? longint'(x0 & FRAC_MASK) : ONE - longint'(x0 & FRAC_MASK);
      ny = neg_y ? longint'(y0 & FRAC_MASK) : ONE - longint'(y0 & FRAC_MASK);
      r.seen  = 1'b0;
      r.steps = STEP_COUNT_W'(WALK_LIMIT);
      for (int k = 0; k < WALK_LIMIT; k++) begin
        if (cx == ex && cy == ey) begin
          r.seen  = 1'b1;
          r.steps = STEP_COUNT_W'(k);
          return r;
        end
        if (adx == 0) go_x = 1'b0;
        else if (ady == 0) go_x = 1'b1;
        else go_x = (nx * ady) < (ny * adx);
        // ties go to y
        if (go_x) begin
          nx += ONE;
          cx += neg_x ? -1 : 1;
        end else begin
          ny += ONE;
          cy += neg_y ? -1 : 1;
        end
        if (cx < 0 || cy < 0 || cx >= MAP_W || cy >= MAP_H ||
            blocked_cell[cy * MAP_W + cx]) begin
          r.steps = STEP_COUNT_W'(k + 1);
          return r;
        end
      end
      return r;
    endfunction

    function void note_beat(cmd_t c);
      if (c.mode == MODE_LOAD) begin
        if (int'(c.col) < MAP_W && int'(c.row) < MAP_H)
          blocked_cell[int'(c.row) * MAP_W + int'(c.col)] = c.blk;
      end else begin
        pending.push_back(trace_sight(c.sx, c.sy, c.fx, c.fy));
      end
    endfunction

    function void check_result(logic vis, logic [STEP_COUNT_W-1:0] cnt);
      sight_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: visible %0b step_count %0d", vis, cnt);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (vis !== want.seen) begin
        $error("visible: expected %0b, actual %0b", want.seen, vis);
        errors++;
      end
      if (cnt !== want.steps) begin
        $error("step_count: expected %0d, actual %0d", want.steps, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    mode_i;
  cell_t                   cell_col_i;
  cell_t                   cell_row_i;
  logic                    cell_blocked_i;
  coord_t                  start_x_i;
  coord_t                  start_y_i;
  coord_t                  finish_x_i;
  coord_t                  finish_y_i;
  logic                    result_valid_o;
  logic                    visible_o;
  logic [STEP_COUNT_W-1:0] step_count_o;

  sight_scoreboard sb;
  int              idle_pct;

  grid_dda_line_of_sight u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .cell_col_i     (cell_col_i),
    .cell_row_i     (cell_row_i),
    .cell_blocked_i (cell_blocked_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .finish_x_i     (finish_x_i),
    .finish_y_i     (finish_y_i),
    .result_valid_o (result_valid_o),
    .visible_o      (visible_o),
    .step_count_o   (step_count_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1)
      sb.check_result(visible_o, step_count_o);
  end

  function automatic logic [FB-1:0] rand_frac();
    case ($urandom_range(7))
      0, 1:    return '0;
      2:       return '1;
      3:       return FB'(1 << (FB - 1));
      default: return FB'($urandom);
    endcase
  endfunction

  function automatic cell_t near_cell(cell_t c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > MAP_W - 1) v = MAP_W - 1;
    return cell_t'(v);
  endfunction

  function automatic cmd_t make_load(int col, int row, logic blk);
    cmd_t c;
    c.mode = MODE_LOAD;
    c.col  = cell_t'(col);
    c.row  = cell_t'(row);
    c.blk  = blk;
    c.sx   = coord_t'($urandom);
    c.sy   = coord_t'($urandom);
    c.fx   = coord_t'($urandom);
    c.fy   = coord_t'($urandom);
    return c;
  endfunction

  function automatic cmd_t make_query(coord_t sx, coord_t sy, coord_t fx, coord_t fy);
    cmd_t c;
    c.mode = MODE_QUERY;
    c.col  = cell_t'($urandom);
    c.row  = cell_t'($urandom);
    c.blk  = 1'($urandom);
    c.sx   = sx;
    c.sy   = sy;
    c.fx   = fx;
    c.fy   = fy;
    return c;
  endfunction

  task automatic send_beat(cmd_t c);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    mode_i         <= c.mode;
    cell_col_i     <= c.col;
    cell_row_i     <= c.row;
    cell_blocked_i <= c.blk;
    start_x_i      <= c.sx;
    start_y_i      <= c.sy;
    finish_x_i     <= c.fx;
    finish_y_i     <= c.fy;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sb.note_beat(c);
  endtask

  task automatic wait_for_answers();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // walled corner: far row and column blocked, every 8th row and column open
  task automatic fill_map();
    bit lane, ring;
    for (int row = 0; row < REGION; row++) begin
      for (int col = 0; col < REGION; col++) begin
        ring = (row == INNER) || (col == INNER);
        lane = (row % 8 == 0) || (col % 8 == 0);
        send_beat(make_load(col, row,
                            ring ? 1'b1 : (lane ? 1'b0 : ($urandom_range(11) == 0))));
      end
    end
  endtask

  task automatic run_directed();
    send_beat(make_load(0, 0, 1'b0));
    send_beat(make_load(9, 10, 1'b0));
    send_beat(make_load(10, 10, 1'b1));
    send_beat(make_load(5, 5, 1'b0));
    send_beat(make_load(5, 6, 1'b0));
    send_beat(make_load(6, 6, 1'b0));
    send_beat(make_load(4, 5, 1'b0));
    send_beat(make_load(63, 63, 1'b1));
    // same cell
    send_beat(make_query(14'h0580, 14'h0580, 14'h05E6, 14'h051A));
    // blocked end cell, no y motion
    send_beat(make_query(14'h0980, 14'h0A80, 14'h0A80, 14'h0A80));
    // corner tie resolves to y
    send_beat(make_query(14'h0580, 14'h0580, 14'h0680, 14'h0680));
    // leaving backward from an exact boundary
    send_beat(make_query(14'h0500, 14'h0580, 14'h0480, 14'h0580));
    send_beat(make_query(14'h0580, 14'h0500, 14'h0580, 14'h0280));
    send_beat(make_query(14'h0080, 14'h0080, 14'h3F80, 14'h0080));
    send_beat(make_query(14'h1E80, 14'h0080, 14'h0080, 14'h0080));
    send_beat(make_query(14'h0880, 14'h1E4D, 14'h0880, 14'h0133));
    send_beat(make_query(14'h0000, 14'h0000, 14'h3FFF, 14'h3FFF));
    send_beat(make_query(14'h1EFF, 14'h1EFF, 14'h0000, 14'h0000));
    send_beat(make_query(14'h0000, 14'h1EFF, 14'h3FFF, 14'h0000));
    send_beat(make_query(14'h0000, 14'h0000, 14'h0000, 14'h0000));
    send_beat(make_query(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF));
    send_beat(make_query(14'h3E80, 14'h3F80, 14'h3F80, 14'h3F80));
    send_beat(make_load(63, 63, 1'b0));
    send_beat(make_query(14'h3E80, 14'h3F80, 14'h3F80, 14'h3F80));
  endtask

  task automatic random_beat();
    cmd_t  c;
    int    col, row, kind;
    cell_t sc_x, sc_y, lane_idx;
    bit    lane;
    if ($urandom_range(9) < 3) begin
      col  = $urandom_range(INNER - 1);
      row  = $urandom_range(INNER - 1);
      lane = (row % 8 == 0) || (col % 8 == 0);
      c = make_load(col, row, lane ? ($urandom_range(31) == 0) : ($urandom_range(7) == 0));
    end else begin
      kind = $urandom_range(9);
      sc_x = cell_t'($urandom_range(INNER - 1));
      sc_y = cell_t'($urandom_range(INNER - 1));
      lane_idx = cell_t'(8 * $urandom_range(3));
      case (kind)
        0, 1, 2, 3:
          c = make_query({sc_x, rand_frac()}, {sc_y, rand_frac()},
                         {near_cell(sc_x), rand_frac()}, {near_cell(sc_y), rand_frac()});
        4, 5:
          if ($urandom_range(1) == 0)
            c = make_query({sc_x, rand_frac()}, {lane_idx, rand_frac()},
                           {cell_t'($urandom), rand_frac()}, {lane_idx, rand_frac()});
          else
            c = make_query({lane_idx, rand_frac()}, {sc_y, rand_frac()},
                           {lane_idx, rand_frac()}, {cell_t'($urandom), rand_frac()});
        6:
          c = make_query({sc_x, FB'(0)}, {sc_y, FB'(0)},
                         {near_cell(sc_x), FB'(0)}, {near_cell(sc_y), FB'(0)});
        default:
          c = make_query({sc_x, FB'($urandom)}, {sc_y, FB'($urandom)},
                         coord_t'($urandom), coord_t'($urandom));
      endcase
    end
    send_beat(c);
  endtask

  initial begin
    int phase_idle [4];
    phase_idle = '{0, 81, 0, 28};
    sb = new();
    idle_pct = 0;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    mode_i         <= MODE_LOAD;
    cell_col_i     <= '0;
    cell_row_i     <= '0;
    cell_blocked_i <= 1'b0;
    start_x_i      <= '0;
    start_y_i      <= '0;
    finish_x_i     <= '0;
    finish_y_i     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fill_map();
    run_directed();
    wait_for_answers();
    // results cannot stall, so the phases vary only the sender's idle gaps
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      repeat (140) random_beat();
      wait_for_answers();
    end
    repeat (WALK_LIMIT + 64) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gdlos_pkg.sv
rtl/grid_dda_line_of_sight.sv
tb/tb_top.sv
